/* rtl/core/cdv_pkg.sv */
// Package: status codes, character constants and the mod-11 check digit function.
`timescale 1ns / 1ps
`default_nettype none

package cdv_pkg;

  typedef enum logic [1:0] {
    STATUS_VALID      = 2'd0,
    STATUS_FORMAT_BAD = 2'd1,
    STATUS_CHECK_BAD  = 2'd2
  } status_e;

  localparam logic [7:0] CH_DOT  = 8'd46;
  localparam logic [7:0] CH_DASH = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  localparam logic [3:0] POS_DOT_A   = 4'd3;
  localparam logic [3:0] POS_DOT_B   = 4'd7;
  localparam logic [3:0] POS_DASH    = 4'd11;
  localparam logic [3:0] POS_CHECK_A = 4'd12;
  localparam logic [3:0] POS_CHECK_B = 4'd13;
  localparam logic [3:0] POS_LENGTH  = 4'd14;
  localparam logic [3:0] POS_MAX     = 4'd15;

  localparam logic [7:0]  RECIP_ELEVEN = 8'd186;  // floor(2^11 / 11)
  localparam logic [10:0] MOD_ELEVEN   = 11'd11;
  localparam logic [4:0]  MOD_TEN      = 5'd10;

  // (x mod 11) mod 10 for x below 1024: reciprocal estimate, one correction.
  function automatic logic [3:0] check_of(input logic [9:0] x);
    logic [17:0] prod;
    logic [6:0]  quot;
    logic [10:0] rem;
    prod = 18'(x) * 18'(RECIP_ELEVEN);
    quot = prod[17:11];
    rem  = 11'(x) - 11'(quot) * MOD_ELEVEN;
    if (rem >= MOD_ELEVEN) begin
      rem = rem - MOD_ELEVEN;
    end
    if (rem[4:0] == MOD_TEN) begin
      rem = '0;
    end
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cpf_check_digit_validator_core.sv */
// Top level: streaming CPF format and mod-11 check digit validator.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------
//  input   | in        | in_valid_i / in_stall_o | ch_i[7:0], last_i
//  result  | out       | out_valid_o/out_stall_i | status_o[1:0]
//
// One character per cycle while in_stall_o is low; a status beat follows the
// last character through the input register, then the result register.
// The character stage holds only when a last character waits behind a
// stalled result beat; other characters pass regardless of the result side.
// Asynchronous active-low reset clears the valid flags and accumulator state.
`timescale 1ns / 1ps
`default_nettype none

module cpf_check_digit_validator_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      ch_i,
  input  wire logic            last_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cdv_pkg::status_e     status_o
);
  import cdv_pkg::*;

  logic       in_valid_q, in_last_q;
  logic [7:0] ch_q;
  logic       in_accept, proceed;

  logic [3:0] pos_q, pos_d;
  logic [8:0] sum1_q, sum1_d, sum2_q, sum2_d;
  logic [3:0] idx_q, idx_d;
  logic       fmt_bad_q, fmt_bad_d;
  logic [3:0] fcd_q, fcd_d;

  logic       out_valid_q;
  status_e    status_q, status_d;

  logic       is_digit, bad_here;
  logic [7:0] d8;
  logic [3:0] d4;
  logic [8:0] prod1, prod2;
  logic [3:0] check1, check2;

  assign proceed    = in_valid_q && (!in_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proceed;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q      <= ch_i;
      in_last_q <= last_i;
    end
  end

  assign d8       = ch_q - CH_ZERO;
  assign d4       = d8[3:0];
  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign prod1    = 9'(d4) * 9'({1'b0, idx_q} + 5'd1);
  assign prod2    = 9'(d4) * 9'(idx_q);
  assign check1   = check_of(10'(sum1_q));
  assign check2   = check_of(10'(sum2_q) + 10'(fcd_q) * 10'd9);

  always_comb begin
    bad_here = 1'b0;
    sum1_d   = sum1_q;
    sum2_d   = sum2_q;
    idx_d    = idx_q;
    fcd_d    = fcd_q;
    priority if (pos_q >= POS_LENGTH) begin
      bad_here = 1'b1;
    end else if (pos_q == POS_DOT_A || pos_q == POS_DOT_B) begin
      bad_here = (ch_q != CH_DOT);
    end else if (pos_q == POS_DASH) begin
      bad_here = (ch_q != CH_DASH);
    end else if (!is_digit) begin
      bad_here = 1'b1;
    end else if (pos_q < POS_DASH) begin
      sum1_d = sum1_q + prod1;
      sum2_d = sum2_q + prod2;
      idx_d  = idx_q + 4'd1;
    end else if (pos_q == POS_CHECK_A) begin
      fcd_d = d4;
    end else begin
      fcd_d = fcd_q;
    end
    fmt_bad_d = fmt_bad_q || bad_here;
    pos_d     = (pos_q < POS_MAX) ? pos_q + 4'd1 : pos_q;

    if (fmt_bad_d || pos_q != POS_CHECK_B) begin
      status_d = STATUS_FORMAT_BAD;
    end else if (fcd_q != check1 || d4 != check2) begin
      status_d = STATUS_CHECK_BAD;
    end else begin
      status_d = STATUS_VALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sum1_q    <= '0;
      sum2_q    <= '0;
      idx_q     <= '0;
      fmt_bad_q <= 1'b0;
      fcd_q     <= '0;
    end else if (proceed) begin
      if (in_last_q) begin
        pos_q     <= '0;
        sum1_q    <= '0;
        sum2_q    <= '0;
        idx_q     <= '0;
        fmt_bad_q <= 1'b0;
        fcd_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        sum1_q    <= sum1_d;
        sum2_q    <= sum2_d;
        idx_q     <= idx_d;
        fmt_bad_q <= fmt_bad_d;
        fcd_q     <= fcd_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && in_last_q) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // end of number clears the accumulators
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed && in_last_q |=> pos_q == '0 && !fmt_bad_q && idx_q == '0)
    else $error("state not cleared after last beat");

  // a processed last character always yields a result beat
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed && in_last_q |=> out_valid_q)
    else $error("missing result beat");

  // input side holds only for a last character blocked by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_last_q && out_valid_q && out_stall_i)
    else $error("input stalled without cause");

  // at most nine leading digits are counted
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd9)
    else $error("digit count overflow");

endmodule

`default_nettype wire
